// File: sv/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only outside reset.
`define RLKS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define RLKS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/rlks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlks_pkg
// Types and constants of the resistor ladder key scanner.
// ----------------------------------------------------------------------------
package rlks_pkg;

  localparam int unsigned NUM_LEVELS = 7;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned REG_DATA_W = 8;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PRESS_THRESHOLD,
    REG_LEVEL_ONE,
    REG_LEVEL_TWO,
    REG_LEVEL_THREE,
    REG_LEVEL_FOUR,
    REG_LEVEL_FIVE,
    REG_LEVEL_SIX,
    REG_LEVEL_SEVEN
  } reg_idx_t;

  // level[0] is level_one ... level[6] is level_seven
  typedef struct packed {
    logic [7:0]                 press_threshold;
    logic [NUM_LEVELS-1:0][7:0] level;
  } cfg_t;

  localparam logic [7:0] PRESS_THRESHOLD_RST = 8'd240;
  localparam logic [NUM_LEVELS-1:0][7:0] LEVEL_RST =
    {8'd200, 8'd170, 8'd140, 8'd110, 8'd80, 8'd50, 8'd20};

  localparam logic [6:0] REPEAT_START  = 7'd50;
  localparam logic [6:0] REPEAT_RELOAD = 7'd40;
  localparam logic [6:0] LONG_LIMIT    = 7'd120;

  localparam logic [2:0] KEY_VOL_UP    = 3'd2;
  localparam logic [2:0] KEY_VOL_DOWN  = 3'd3;
  localparam logic [2:0] KEY_PHONE_OFF = 3'd5;
  localparam logic [2:0] KEY_PHONE_ON  = 3'd6;

  typedef struct packed {
    logic [7:0] sample;
    logic       tick_due;
    logic       accessory_on;
  } in_t;

  typedef struct packed {
    logic [2:0] key_code;
    logic       combination_queue;
    logic       last;
  } out_t;

  // Results of one item, handed from the front end to the queue.
  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } res_pair_t;

endpackage

// File: sv/rlks_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlks_cfg
// Configuration register file: press threshold and seven ladder band bounds.
// ----------------------------------------------------------------------------
module rlks_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [rlks_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [rlks_pkg::REG_DATA_W-1:0]  wr_data,
  output rlks_pkg::cfg_t                   cfg
);

  logic [rlks_pkg::REG_IDX_W-1:0] level_sel;

  assign level_sel = wr_index - rlks_pkg::REG_IDX_W'(rlks_pkg::REG_LEVEL_ONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_threshold <= rlks_pkg::PRESS_THRESHOLD_RST;
      cfg.level           <= rlks_pkg::LEVEL_RST;
    end else if (wr_en) begin
      if (wr_index == rlks_pkg::REG_PRESS_THRESHOLD) begin
        cfg.press_threshold <= wr_data;
      end else begin
        cfg.level[level_sel] <= wr_data;
      end
    end
  end

endmodule

// File: sv/rlks_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlks_front
// Scan state machine: takes one tick per cycle while accepted, updates the
// press state and produces up to two key reports for the result queue.
// ----------------------------------------------------------------------------
module rlks_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  rlks_pkg::in_t        item,
  input  rlks_pkg::cfg_t       cfg,
  output rlks_pkg::res_pair_t  wr
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONFIRM,
    S_HELD,
    S_RELEASE
  } mode_t;

  mode_t      mode;
  logic [7:0] first_sample;
  logic [7:0] held_sample;
  logic [6:0] hold_ticks;

  logic       active;
  logic       pressed;
  logic [6:0] ticks_inc;
  logic [6:0] ticks_rep;
  logic       vol_hit;
  logic       long_hit;
  logic       band_found;
  logic [2:0] band_code;
  logic [1:0] n_res;
  rlks_pkg::out_t vol_res;
  rlks_pkg::out_t rep_res;

  assign active  = accept && item.tick_due && item.accessory_on;
  assign pressed = item.sample < cfg.press_threshold;

  assign ticks_inc = hold_ticks + 7'd1;
  assign vol_hit   = (held_sample <= cfg.level[1]) && (ticks_inc > rlks_pkg::REPEAT_START);
  assign ticks_rep = vol_hit ? rlks_pkg::REPEAT_RELOAD : ticks_inc;
  assign long_hit  = ticks_rep > rlks_pkg::LONG_LIMIT;

  // first band (lowest index) whose bound covers the held value wins
  always_comb begin
    band_found = 1'b0;
    band_code  = '0;
    for (int b = rlks_pkg::NUM_LEVELS - 1; b >= 0; b--) begin
      if (held_sample <= cfg.level[b]) begin
        band_found = 1'b1;
        band_code  = 3'(b);
      end
    end
  end

  always_comb begin
    vol_res.key_code          = (held_sample <= cfg.level[0]) ? rlks_pkg::KEY_VOL_DOWN
                                                              : rlks_pkg::KEY_VOL_UP;
    vol_res.combination_queue = 1'b0;
    vol_res.last              = 1'b0;
    rep_res.key_code          = band_code;
    rep_res.combination_queue = band_code >= rlks_pkg::KEY_PHONE_OFF;
    rep_res.last              = 1'b0;
  end

  // Repeat and long press exclude each other, so the second result, when
  // there is one, is always the release report.
  always_comb begin
    n_res = 2'(vol_hit) + 2'(long_hit && band_found) + 2'(!pressed && band_found);
    if (!(active && mode == S_HELD)) begin
      n_res = '0;
    end
    wr.count  = n_res;
    wr.first  = vol_hit ? vol_res : rep_res;
    wr.second = rep_res;
    wr.first.last  = (n_res == 2'd1);
    wr.second.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= S_IDLE;
      first_sample <= '0;
      held_sample  <= '0;
      hold_ticks   <= '0;
    end else if (active) begin
      case (mode)
        S_IDLE: begin
          if (pressed) begin
            mode         <= S_CONFIRM;
            hold_ticks   <= '0;
            first_sample <= item.sample;
          end
        end
        S_CONFIRM: begin
          if (item.sample == first_sample) begin
            mode        <= S_HELD;
            held_sample <= item.sample;
          end else begin
            mode <= S_IDLE;
          end
        end
        S_HELD: begin
          hold_ticks <= long_hit ? 7'd0 : ticks_rep;
          if (long_hit || !pressed) begin
            mode <= S_RELEASE;
          end
        end
        default: begin
          if (!pressed) begin
            mode <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// File: sv/rlks_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlks_fifo
// Four-entry result queue: up to two writes per cycle, one read.
// ----------------------------------------------------------------------------
module rlks_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  rlks_pkg::res_pair_t  wr,
  input  logic                 pop,
  output logic                 full,
  output logic                 empty,
  output rlks_pkg::out_t       result
);

  rlks_pkg::out_t mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       do_pop;

  assign do_pop = pop && !empty;
  assign empty  = (count == 3'd0);
  // keep room for the two results one item may cause
  assign full   = (count > 3'd2);
  assign result = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr.count != 2'd0) begin
      mem[wr_ptr] <= wr.first;
    end
    if (wr.count == 2'd2) begin
      mem[wr_ptr + 2'd1] <= wr.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + wr.count;
      rd_ptr <= rd_ptr + 2'(do_pop);
      count  <= count + 3'(wr.count) - 3'(do_pop);
    end
  end

endmodule

// File: sv/resistor_ladder_key_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resistor_ladder_key_scanner
// Ladder key scanner: debounce, hold timing, volume repeat and key reports.
// ----------------------------------------------------------------------------
//  channel  | ports                     | transfer when
//  ---------+---------------------------+---------------------
//  input    | push, full, item          | push && !full
//  results  | empty, pop, result        | pop && !empty
//  config   | wr_en, wr_index, wr_data  | wr_en
//
// One tick is taken per cycle while full is low; its reports land in the
// queue the next cycle. Results drain one per cycle while pop is high, from
// a four-entry queue; full is raised while fewer than two entries are free,
// the most one tick can produce. Reset (rst, synchronous) clears the scan
// state and queue and restores the register defaults; no warm-up is needed.
module resistor_ladder_key_scanner (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  rlks_pkg::in_t                    item,
  output logic                             empty,
  input  logic                             pop,
  output rlks_pkg::out_t                   result,
  input  logic                             wr_en,
  input  logic [rlks_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [rlks_pkg::REG_DATA_W-1:0]  wr_data
);

  rlks_pkg::cfg_t      cfg;
  rlks_pkg::res_pair_t wr;
  logic                accept;

  assign accept = push && !full;

  rlks_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  rlks_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cfg    (cfg),
    .wr     (wr)
  );

  rlks_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .pop    (pop),
    .full   (full),
    .empty  (empty),
    .result (result)
  );

endmodule

// File: sv/rlks_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlks_checker
// Port-level checks of the key scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlks_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic                             full,
  input  rlks_pkg::in_t                    item,
  input  logic                             empty,
  input  logic                             pop,
  input  rlks_pkg::out_t                   result,
  input  logic                             wr_en,
  input  logic [rlks_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [rlks_pkg::REG_DATA_W-1:0]  wr_data
);

  logic ignored_tick;
  logic flag_ok;

  assign ignored_tick = push && !full && !(item.tick_due && item.accessory_on);
  // phone off and phone on go to the combination queue, every other key does not
  assign flag_ok = result.combination_queue ==
                   ((result.key_code == rlks_pkg::KEY_PHONE_OFF) ||
                    (result.key_code == rlks_pkg::KEY_PHONE_ON));

  `RLKS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> empty, "queue not empty after reset")
  `RLKS_ASSERT(a_full_not_empty, clk, rst, full |-> !empty, "full while queue empty")
  `RLKS_ASSERT(a_queue_select, clk, rst, !empty |-> flag_ok, "queue flag disagrees with key")
  `RLKS_ASSERT(a_ignored_tick, clk, rst, empty && ignored_tick |=> empty, "ignored tick queued")

endmodule

bind resistor_ladder_key_scanner rlks_checker u_rlks_checker (.*);

// File: test/tb_resistor_ladder_key_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_resistor_ladder_key_scanner
// Self-checking bench for the ladder key scanner. A short table of scan ticks
// walks press, confirm, hold and release through the main bands; random
// press sequences then run under eight register settings and four
// flow-control patterns. Every popped report is compared with a behavioral
// model of the scan state machine kept inside the bench.
// ----------------------------------------------------------------------------
module tb_resistor_ladder_key_scanner;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_TICKS    = 28;

  localparam logic [2:0] KEY_NEXT = 3'd0;
  localparam logic [2:0] KEY_PREV = 3'd1;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_CONFIRM,
    SCAN_HELD,
    SCAN_WAIT_RELEASE
  } scan_state_t;

  typedef struct packed {
    rlks_pkg::in_t  stim;
    logic           typed;
    logic           has_key;
    rlks_pkg::out_t key;
  } ladder_row_t;

  logic                            clk;
  logic                            rst      = 1'b1;
  logic                            push     = 1'b0;
  logic                            full;
  rlks_pkg::in_t                   item     = '0;
  logic                            empty;
  logic                            pop      = 1'b0;
  rlks_pkg::out_t                  result;
  logic                            wr_en    = 1'b0;
  logic [rlks_pkg::REG_IDX_W-1:0]  wr_index = '0;
  logic [rlks_pkg::REG_DATA_W-1:0] wr_data  = '0;

  // bench copy of the scanner
  logic [7:0]     cfg_regs [8];
  scan_state_t    scan_state;
  logic [7:0]     first_seen;
  logic [7:0]     held_value;
  logic [6:0]     held_ticks;
  rlks_pkg::out_t tick_keys [2];
  int             tick_count;

  rlks_pkg::out_t pending_keys [$];
  rlks_pkg::out_t want;
  ladder_row_t    directed_rows [26];

  int sender_idle_pct = 0;
  int pop_stall_pct   = 0;
  int scan_ticks      = 0;
  int ignored_ticks   = 0;
  int keys_checked    = 0;
  int errors          = 0;
  int quiet_cycles    = 0;

  resistor_ladder_key_scanner uut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    errors++;
  endtask

  task automatic add_key(input logic [2:0] code, input logic comb);
    if (tick_count < 2) begin
      tick_keys[tick_count] = '{key_code: code, combination_queue: comb, last: 1'b0};
      tick_count++;
    end
  endtask

  // first band whose upper bound covers the value wins; above all bands: no key
  task automatic report_band(input logic [7:0] v);
    bit found;
    found = 1'b0;
    for (int b = 0; b < rlks_pkg::NUM_LEVELS; b++) begin
      if (!found && v <= cfg_regs[rlks_pkg::REG_LEVEL_ONE + b]) begin
        add_key(3'(b), 3'(b) >= rlks_pkg::KEY_PHONE_OFF);
        found = 1'b1;
      end
    end
  endtask

  task automatic predict_tick(input rlks_pkg::in_t it);
    logic pressed;
    tick_count = 0;
    if (it.tick_due && it.accessory_on) begin
      pressed = it.sample < cfg_regs[rlks_pkg::REG_PRESS_THRESHOLD];
      case (scan_state)
        SCAN_IDLE: begin
          if (pressed) begin
            scan_state = SCAN_CONFIRM;
            held_ticks = '0;
            first_seen = it.sample;
          end
        end
        SCAN_CONFIRM: begin
          if (it.sample == first_seen) begin
            scan_state = SCAN_HELD;
            held_value = it.sample;
          end else begin
            scan_state = SCAN_IDLE;
          end
        end
        SCAN_HELD: begin
          // counter first, then volume repeat, long press, release
          held_ticks = held_ticks + 7'd1;
          if (held_value <= cfg_regs[rlks_pkg::REG_LEVEL_TWO] &&
              held_ticks > rlks_pkg::REPEAT_START) begin
            held_ticks = rlks_pkg::REPEAT_RELOAD;
            add_key(held_value <= cfg_regs[rlks_pkg::REG_LEVEL_ONE] ?
                    rlks_pkg::KEY_VOL_DOWN : rlks_pkg::KEY_VOL_UP, 1'b0);
          end
          if (held_ticks > rlks_pkg::LONG_LIMIT) begin
            held_ticks = '0;
            report_band(held_value);
            scan_state = SCAN_WAIT_RELEASE;
          end
          if (!pressed) begin
            report_band(held_value);
            scan_state = SCAN_WAIT_RELEASE;
          end
        end
        default: begin
          if (!pressed) scan_state = SCAN_IDLE;
        end
      endcase
      if (tick_count > 0) tick_keys[tick_count-1].last = 1'b1;
    end
  endtask

  task automatic send_item(input rlks_pkg::in_t it, input bit from_model);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    predict_tick(it);
    if (it.tick_due && it.accessory_on) scan_ticks++;
    else ignored_ticks++;
    if (from_model) begin
      for (int k = 0; k < tick_count; k++) pending_keys.push_back(tick_keys[k]);
    end
  endtask

  // random ignored tick in front of some processed ones
  task automatic send_tick(input logic [7:0] s);
    rlks_pkg::in_t noise;
    if ($urandom_range(0, 99) < 8) begin
      noise.sample = 8'($urandom);
      {noise.tick_due, noise.accessory_on} = 2'($urandom_range(0, 2));
      send_item(noise, 1'b1);
    end
    send_item('{sample: s, tick_due: 1'b1, accessory_on: 1'b1}, 1'b1);
  endtask

  task automatic wait_until_drained();
    push <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    // a tick with no report may still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input rlks_pkg::reg_idx_t idx, input logic [7:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    cfg_regs[idx] = val;
  endtask

  function automatic logic [7:0] down_sample();
    if (cfg_regs[rlks_pkg::REG_PRESS_THRESHOLD] == 8'd0) return 8'($urandom);
    return 8'($urandom_range(0, cfg_regs[rlks_pkg::REG_PRESS_THRESHOLD] - 1));
  endfunction

  function automatic logic [7:0] up_sample();
    return 8'($urandom_range(cfg_regs[rlks_pkg::REG_PRESS_THRESHOLD], 255));
  endfunction

  // press values lean toward the band edges
  function automatic logic [7:0] pick_press();
    logic [7:0] v;
    if ($urandom_range(0, 99) < 30)
      v = cfg_regs[$urandom_range(1, 7)] + 8'($urandom_range(0, 1));
    else
      v = down_sample();
    if (v >= cfg_regs[rlks_pkg::REG_PRESS_THRESHOLD]) v = down_sample();
    return v;
  endfunction

  task automatic run_random(input int budget);
    int         start_count;
    int         kind;
    int         hold_len;
    logic [7:0] v;
    start_count = scan_ticks;
    while (scan_ticks - start_count < budget) begin
      kind = $urandom_range(0, 99);
      v    = pick_press();
      if (kind < 75) begin
        send_tick(v);
        send_tick(v);
        if ($urandom_range(0, 99) < 15)
          hold_len = ($urandom_range(0, 2) == 0) ? 120 : $urandom_range(45, 130);
        else
          hold_len = $urandom_range(0, 8);
        repeat (hold_len) send_tick(down_sample());
        send_tick(up_sample());
        repeat ($urandom_range(0, 2))
          send_tick($urandom_range(0, 1) ? down_sample() : up_sample());
        send_tick(up_sample());
      end else if (kind < 87) begin
        // confirmation broken by a one-bit change
        send_tick(v);
        send_tick(v ^ (8'd1 << $urandom_range(0, 7)));
        send_tick(up_sample());
      end else begin
        repeat ($urandom_range(1, 4)) send_tick(8'($urandom));
      end
    end
  endtask

  function automatic ladder_row_t row_model(logic [7:0] s, logic t, logic a);
    return '{stim: '{s, t, a}, typed: 1'b0, has_key: 1'b0, key: '0};
  endfunction

  function automatic ladder_row_t row_quiet(logic [7:0] s, logic t, logic a);
    return '{stim: '{s, t, a}, typed: 1'b1, has_key: 1'b0, key: '0};
  endfunction

  function automatic ladder_row_t row_key(logic [7:0] s, logic [2:0] code);
    return '{stim: '{s, 1'b1, 1'b1}, typed: 1'b1, has_key: 1'b1,
             key: '{key_code: code, combination_queue: code >= rlks_pkg::KEY_PHONE_OFF,
                    last: 1'b1}};
  endfunction

  always @(posedge clk) begin
    pop <= ($urandom_range(0, 99) >= pop_stall_pct);
  end

  // report checker
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_keys.size() == 0) begin
        report_mismatch($sformatf("key report %0d/%0d/%0d with nothing expected",
                                  result.key_code, result.combination_queue, result.last));
      end else begin
        want = pending_keys.pop_front();
        if (result.key_code !== want.key_code)
          report_mismatch($sformatf("key_code %0d, expected %0d",
                                    result.key_code, want.key_code));
        if (result.combination_queue !== want.combination_queue)
          report_mismatch($sformatf("combination_queue %0b, expected %0b",
                                    result.combination_queue, want.combination_queue));
        if (result.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", result.last, want.last));
        keys_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || wr_en) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d reports outstanding",
               WATCHDOG_LIMIT, pending_keys.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] vals [8];
    int         lvl;

    cfg_regs[rlks_pkg::REG_PRESS_THRESHOLD] = rlks_pkg::PRESS_THRESHOLD_RST;
    for (int i = 0; i < rlks_pkg::NUM_LEVELS; i++)
      cfg_regs[rlks_pkg::REG_LEVEL_ONE + i] = rlks_pkg::LEVEL_RST[i];
    scan_state = SCAN_IDLE;
    first_seen = '0;
    held_value = '0;
    held_ticks = '0;
    tick_count = 0;

    directed_rows = '{
      row_quiet(8'd0,   1'b0, 1'b1),   // no tick
      row_quiet(8'd0,   1'b1, 1'b0),   // no accessory power
      row_quiet(8'hFF,  1'b0, 1'b0),
      row_model(8'd255, 1'b1, 1'b1),
      row_model(8'd0,   1'b1, 1'b1),
      row_model(8'd0,   1'b1, 1'b1),
      row_key  (8'd255, KEY_NEXT),
      row_model(8'd255, 1'b1, 1'b1),
      row_model(8'd239, 1'b1, 1'b1),
      row_model(8'd238, 1'b1, 1'b1),   // confirmation fails
      row_model(8'd239, 1'b1, 1'b1),
      row_model(8'd239, 1'b1, 1'b1),
      row_quiet(8'd240, 1'b1, 1'b1),   // held value above every band
      row_model(8'd240, 1'b1, 1'b1),
      row_model(8'd170, 1'b1, 1'b1),
      row_model(8'd170, 1'b1, 1'b1),
      row_model(8'd100, 1'b1, 1'b1),   // still down, different reading
      row_key  (8'd250, rlks_pkg::KEY_PHONE_OFF),
      row_model(8'd250, 1'b1, 1'b1),
      row_model(8'd200, 1'b1, 1'b1),
      row_model(8'd200, 1'b1, 1'b1),
      row_key  (8'd255, rlks_pkg::KEY_PHONE_ON),
      row_model(8'd255, 1'b1, 1'b1),
      row_model(8'd50,  1'b1, 1'b1),
      row_model(8'd50,  1'b1, 1'b1),
      row_key  (8'd241, KEY_PREV)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].stim, !directed_rows[r].typed);
      if (directed_rows[r].typed) begin
        if (tick_count != int'(directed_rows[r].has_key) ||
            (directed_rows[r].has_key && tick_keys[0] != directed_rows[r].key))
          report_mismatch($sformatf("table row %0d disagrees with bench model", r));
        if (directed_rows[r].has_key) pending_keys.push_back(directed_rows[r].key);
      end
    end

    for (int p = 0; p < 8; p++) begin
      wait_until_drained();
      case (p)
        1: foreach (vals[i]) vals[i] = 8'hFF;
        2: foreach (vals[i]) vals[i] = 8'h00;
        3, 6: begin
          vals[0] = 8'($urandom_range(128, 255));
          lvl = 0;
          for (int i = 1; i < 8; i++) begin
            lvl += $urandom_range(0, 36);
            vals[i] = 8'(lvl);
          end
        end
        4: foreach (vals[i]) vals[i] = 8'($urandom);
        5: begin
          vals[0] = 8'hFF;
          for (int i = 1; i < 8; i++) vals[i] = 8'h00;
        end
        default: begin
          vals[0] = rlks_pkg::PRESS_THRESHOLD_RST;
          for (int i = 1; i < 8; i++) vals[i] = rlks_pkg::LEVEL_RST[i-1];
        end
      endcase
      for (int i = 0; i < 8; i++) write_reg(rlks_pkg::reg_idx_t'(i), vals[i]);
      wr_en <= 1'b0;

      case (p % 4)
        0: begin sender_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin sender_idle_pct = 70; pop_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  pop_stall_pct = 70; end
        default: begin sender_idle_pct = 8; pop_stall_pct = 8; end
      endcase

      if (p == 3) begin
        run_random(PHASE_TICKS / 2);
        wait_until_drained();
        run_random(PHASE_TICKS / 2);
      end else begin
        run_random(PHASE_TICKS);
      end
    end

    wait_until_drained();

    repeat (16) @(posedge clk);
    if (pending_keys.size() != 0)
      report_mismatch($sformatf("%0d key reports never arrived", pending_keys.size()));

    $display("Ran %0d scan ticks and %0d ignored ticks over 8 register settings,",
             scan_ticks, ignored_ticks);
    $display("%0d key reports checked with sender idling and receiver stalls.",
             keys_checked);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/rlks_pkg.sv
sv/rlks_cfg.sv
sv/rlks_front.sv
sv/rlks_fifo.sv
sv/resistor_ladder_key_scanner.sv
sv/rlks_checker.sv
test/tb_resistor_ladder_key_scanner.sv
